### src/rwtm_pkg.sv
package rwtm_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 24;

    // register indexes on the configuration port
    localparam logic [CfgAddrW-1:0] RegScreenW = 3'd0;
    localparam logic [CfgAddrW-1:0] RegScreenH = 3'd1;
    localparam logic [CfgAddrW-1:0] RegTexW    = 3'd2;
    localparam logic [CfgAddrW-1:0] RegTexH    = 3'd3;
    localparam logic [CfgAddrW-1:0] RegProj    = 3'd4;

    // wall face codes
    localparam logic [2:0] FaceSouth = 3'd0;
    localparam logic [2:0] FaceNorth = 3'd1;
    localparam logic [2:0] FaceEast  = 3'd2;
    localparam logic [2:0] FaceWest  = 3'd3;

    // sideband carried through the column divider
    typedef struct packed {
        logic [11:0] px;
        logic [11:0] y;
        logic [2:0]  face;
        logic [34:0] prod;
        logic [23:0] len;
    } t_cside;

    // sideband carried through the height divider
    typedef struct packed {
        logic [11:0] px;
        logic [11:0] y;
        logic [9:0]  col;
        logic        sat;
    } t_hside;

    // sideband carried through the row divider
    typedef struct packed {
        logic [11:0] px;
        logic [11:0] y;
        logic [9:0]  col;
        logic        in_span;
    } t_rside;

endpackage

### src/rwtm_divpipe.sv
module rwtm_divpipe #(
    parameter int DW = 24,
    parameter int QW = 32,
    parameter int SW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [DW-1:0]    o_rem,
    output logic [SW-1:0]    o_side
);
    // restoring division, one quotient bit per stage
    // the upper DW bits of i_num must be below i_den

    logic [DW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_lq   [0:QW-1];
    logic [DW-1:0] r_den  [0:QW-1];
    logic [SW-1:0] r_side [0:QW-1];
    logic          r_vld  [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] c_rem;
        logic [QW-1:0] c_lq;
        logic [DW-1:0] c_den;
        logic [SW-1:0] c_side;
        logic          c_vld;
        logic [DW:0]   c_t;
        logic          c_ge;

        if (k == 0) begin : g_first
            assign c_rem  = i_num[DW+QW-1:QW];
            assign c_lq   = i_num[QW-1:0];
            assign c_den  = i_den;
            assign c_side = i_side;
            assign c_vld  = i_valid;
        end else begin : g_next
            assign c_rem  = r_rem[k-1];
            assign c_lq   = r_lq[k-1];
            assign c_den  = r_den[k-1];
            assign c_side = r_side[k-1];
            assign c_vld  = r_vld[k-1];
        end

        assign c_t  = {c_rem, c_lq[QW-1]};
        assign c_ge = (c_t >= {1'b0, c_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_ge ? DW'(c_t - {1'b0, c_den}) : c_t[DW-1:0];
                r_lq[k]   <= {c_lq[QW-2:0], c_ge};
                r_den[k]  <= c_den;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_lq[QW-1];
    assign o_rem   = r_rem[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### src/rwtm_front.sv
module rwtm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [11:0]           i_ray_index,
    input  logic [23:0]           i_ray_length,
    input  logic [15:0]           i_hit_x,
    input  logic [15:0]           i_hit_y,
    input  logic [2:0]            i_wall_face,
    input  logic [11:0]           i_screen_row,
    input  logic [12:0]           i_screen_width,
    input  logic [10:0]           i_tw,
    input  logic [23:0]           i_proj_dist,
    output logic                  o_valid,
    output logic [15:0]           o_coord,
    output rwtm_pkg::t_cside      o_side
);
    import rwtm_pkg::*;

    logic        r_vld;
    logic [15:0] r_coord;
    t_cside      r_side;
    logic [15:0] n_coord;
    t_cside      n_side;

    always_comb begin
        case (i_wall_face)
            FaceSouth, FaceNorth: n_coord = i_hit_x;
            FaceEast, FaceWest:   n_coord = i_hit_y;
            default:              n_coord = 16'd0;
        endcase
        n_side.px   = 12'(i_screen_width - {1'b0, i_ray_index} - 13'd1);
        n_side.y    = i_screen_row;
        n_side.face = i_wall_face;
        n_side.prod = 35'(i_tw) * 35'(i_proj_dist);
        n_side.len  = i_ray_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= n_coord;
            r_side  <= n_side;
        end
    end

    assign o_valid = r_vld;
    assign o_coord = r_coord;
    assign o_side  = r_side;

endmodule

### src/raycast_wall_texel_mapper_core.sv
// channel   | dir | tvalid/tready                   | tdata / tuser
// ----------+-----+---------------------------------+---------------------------------------
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | ray item (fields below)
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | texel address item (fields below)
// cfg       | in  | i_cfg_we, no ready              | i_cfg_addr register index, i_cfg_wdata
//
// one item per cycle while the output is taken; the pipeline is built around the three
// bit-per-stage divider pipelines (column mod, slice height, texture row)
// reset: synchronous active low, clears all stage valid bits and loads register defaults
// stalls: the whole pipeline holds while the output register is full and not taken,
// so no item is lost or repeated; input is taken whenever the output can move
module raycast_wall_texel_mapper_core #(
    parameter int MAX_TEXTURE_SIZE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // ray_index [11:0], ray_length [35:12], hit_x [51:36], hit_y [67:52],
    // screen_row [79:68]
    input  logic [79:0]                   i_s_axis_tdata,
    // wall_face [2:0]
    input  logic [2:0]                    i_s_axis_tuser,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // pixel_x [11:0], pixel_y [23:12], tex_col [33:24], tex_row [43:34], zero [47:44]
    output logic [47:0]                   o_m_axis_tdata,
    // in_wall [0]
    output logic [0:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [rwtm_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [rwtm_pkg::CfgDataW-1:0] i_cfg_wdata
);
    import rwtm_pkg::*;

    // texture sizes are clamped to this, never above what 11 bits hold
    localparam int TexCap = (MAX_TEXTURE_SIZE > 2047) ? 2047 : MAX_TEXTURE_SIZE;
    localparam logic [10:0] TexCapV = TexCap[10:0];

    // configuration registers
    logic [12:0] r_scr_w;
    logic [12:0] r_scr_h;
    logic [10:0] r_tex_w;
    logic [10:0] r_tex_h;
    logic [23:0] r_proj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= 13'd640;
            r_scr_h <= 13'd480;
            r_tex_w <= 11'd64;
            r_tex_h <= 11'd64;
            r_proj  <= 24'd126157;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegScreenW: r_scr_w <= i_cfg_wdata[12:0];
                RegScreenH: r_scr_h <= i_cfg_wdata[12:0];
                RegTexW:    r_tex_w <= i_cfg_wdata[10:0];
                RegTexH:    r_tex_h <= i_cfg_wdata[10:0];
                RegProj:    r_proj  <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    logic [10:0] tw;
    logic [10:0] th;
    assign tw = (r_tex_w > TexCapV) ? TexCapV : r_tex_w;
    assign th = (r_tex_h > TexCapV) ? TexCapV : r_tex_h;

    // global advance: everything moves when the output register can
    logic en;
    logic r_out_vld;
    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 0: operand prep, tw * proj_dist, mirrored column
    logic        f_vld;
    logic [15:0] f_coord;
    t_cside      f_side;

    rwtm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_s_axis_tvalid),
        .i_ray_index    (i_s_axis_tdata[11:0]),
        .i_ray_length   (i_s_axis_tdata[35:12]),
        .i_hit_x        (i_s_axis_tdata[51:36]),
        .i_hit_y        (i_s_axis_tdata[67:52]),
        .i_wall_face    (i_s_axis_tuser),
        .i_screen_row   (i_s_axis_tdata[79:68]),
        .i_screen_width (r_scr_w),
        .i_tw           (tw),
        .i_proj_dist    (r_proj),
        .o_valid        (f_vld),
        .o_coord        (f_coord),
        .o_side         (f_side)
    );

    // hit coordinate mod texture width
    logic        c_vld;
    logic [15:0] c_quo;
    logic [10:0] c_rem;
    logic [$bits(t_cside)-1:0] c_side_v;
    t_cside      c_side;

    rwtm_divpipe #(.DW(11), .QW(16), .SW($bits(t_cside))) u_coldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_vld),
        .i_num   ({11'd0, f_coord}),
        .i_den   ((tw == 11'd0) ? 11'd1 : tw),
        .i_side  (f_side),
        .o_valid (c_vld),
        .o_quo   (c_quo),
        .o_rem   (c_rem),
        .o_side  (c_side_v)
    );
    assign c_side = t_cside'(c_side_v);

    // texture column by face, then slice height operands
    logic [10:0] col_full;
    logic [10:0] mirror;
    logic [10:0] n_hi;
    logic        sat;
    t_hside      h_in;

    assign mirror = (c_rem == 11'd0) ? 11'd0 : 11'(tw - c_rem);

    always_comb begin
        if (tw == 11'd0) begin
            col_full = 11'd0;
        end else begin
            case (c_side.face)
                FaceSouth, FaceEast: col_full = mirror;
                FaceNorth, FaceWest: col_full = c_rem;
                default:             col_full = tw >> 1;
            endcase
        end
    end

    // hq saturates when the quotient reaches 2^32, which includes a zero length
    assign n_hi = c_side.prod[34:24];
    assign sat  = (c_side.len == 24'd0) || ({13'd0, n_hi} >= c_side.len);

    always_comb begin
        h_in.px  = c_side.px;
        h_in.y   = c_side.y;
        h_in.col = col_full[9:0];
        h_in.sat = sat;
    end

    logic        h_vld;
    logic [31:0] h_quo;
    logic [23:0] h_rem;
    logic [$bits(t_hside)-1:0] h_side_v;
    t_hside      h_side;

    rwtm_divpipe #(.DW(24), .QW(32), .SW($bits(t_hside))) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_vld),
        .i_num   (sat ? 56'd0 : {13'd0, c_side.prod, 8'd0}),
        .i_den   (sat ? 24'd1 : c_side.len),
        .i_side  (h_in),
        .o_valid (h_vld),
        .o_quo   (h_quo),
        .o_rem   (h_rem),
        .o_side  (h_side_v)
    );
    assign h_side = t_hside'(h_side_v);

    // span stage: a, b, in-wall test and row offset
    logic [32:0] hqc;
    logic [20:0] hs;
    logic        full;
    logic [20:0] lo_diff;
    logic [21:0] hi_sum;
    logic [12:0] span_a;
    logic [12:0] span_b;
    logic        n_sp_inside;

    assign hqc     = h_side.sat ? 33'h1_0000_0000 : {1'b0, h_quo};
    assign hs      = {r_scr_h, 8'd0};
    assign full    = (hqc >= {12'd0, hs});
    assign lo_diff = hs - hqc[20:0];
    assign hi_sum  = {1'b0, hs} + {1'b0, hqc[20:0]};
    assign span_a  = full ? 13'd0 : {1'b0, lo_diff[20:9]};
    assign span_b  = full ? r_scr_h : hi_sum[21:9];
    assign n_sp_inside = ({1'b0, h_side.y} >= span_a) && ({1'b0, h_side.y} < span_b);

    logic        r_sp_vld;
    logic        r_sp_inside;
    logic [11:0] r_sp_diff;
    logic [32:0] r_sp_hq;
    logic [11:0] r_sp_px;
    logic [11:0] r_sp_y;
    logic [9:0]  r_sp_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_vld <= 1'b0;
        end else if (en) begin
            r_sp_vld <= h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp_inside <= n_sp_inside;
            r_sp_diff   <= h_side.y - span_a[11:0];
            r_sp_hq     <= hqc;
            r_sp_px     <= h_side.px;
            r_sp_y      <= h_side.y;
            r_sp_col    <= h_side.col;
        end
    end

    // multiply stage: (y - a) * th, scaled by 256
    logic        n_mu_ok;
    logic        r_mu_vld;
    logic        r_mu_ok;
    logic [22:0] r_mu_prod;
    logic [32:0] r_mu_hq;
    t_rside      r_mu_side;

    assign n_mu_ok = r_sp_inside && (r_sp_hq != 33'd0) && (th != 11'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_vld <= 1'b0;
        end else if (en) begin
            r_mu_vld <= r_sp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mu_ok           <= n_mu_ok;
            r_mu_prod         <= 23'(r_sp_diff) * 23'(th);
            r_mu_hq           <= r_sp_hq;
            r_mu_side.px      <= r_sp_px;
            r_mu_side.y       <= r_sp_y;
            r_mu_side.col     <= r_sp_col;
            r_mu_side.in_span <= r_sp_inside;
        end
    end

    // texture row divider; quotient never exceeds th
    logic        r_vld_div;
    logic [10:0] r_quo;
    logic [32:0] r_rem_unused;
    logic [$bits(t_rside)-1:0] r_side_v;
    t_rside      rd_side;

    rwtm_divpipe #(.DW(33), .QW(11), .SW($bits(t_rside))) u_rowdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mu_vld),
        .i_num   (r_mu_ok ? {13'd0, r_mu_prod, 8'd0} : 44'd0),
        .i_den   (r_mu_ok ? r_mu_hq : 33'd1),
        .i_side  (r_mu_side),
        .o_valid (r_vld_div),
        .o_quo   (r_quo),
        .o_rem   (r_rem_unused),
        .o_side  (r_side_v)
    );
    assign rd_side = t_rside'(r_side_v);

    // output register; a row equal to th wraps to zero
    logic [11:0] r_out_px;
    logic [11:0] r_out_y;
    logic [9:0]  r_out_col;
    logic [9:0]  r_out_row;
    logic        r_out_in;
    logic [10:0] n_row;

    assign n_row = (r_quo == th) ? 11'd0 : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_px  <= rd_side.px;
            r_out_y   <= rd_side.y;
            r_out_col <= rd_side.col;
            r_out_in  <= rd_side.in_span;
            r_out_row <= n_row[9:0];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'd0, r_out_row, r_out_col, r_out_y, r_out_px};
    assign o_m_axis_tuser  = r_out_in;

`ifndef SYNTH
    // rows outside the wall never carry a texture row
    a_row_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[43:34] == 10'd0)
        else $error("tex_row nonzero outside wall");

    // a stall holds the span stage
    a_span_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_sp_vld) && $stable(r_sp_diff) && $stable(r_sp_inside))
        else $error("span stage moved during stall");

    // an item outside the span never arms the row division
    a_no_div_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !r_sp_inside |=> !r_mu_ok)
        else $error("row division armed outside span");

    // a full output register that is not taken blocks the input
    a_block_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while output stalled");
`endif

endmodule
